// ----- design/wfcrc8_pkg.sv -----
// shared types, constants and crc function for the weather frame crc8 decoder
`timescale 1ns / 1ps

package wfcrc8_pkg;

	localparam logic [7:0] CRC_POLY      = 8'h31;
	localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
	localparam logic [7:0] BATTERY_MASK  = 8'h80;
	localparam int         PAYLOAD_DEPTH = 14;
	localparam int         COUNT_W       = 5;
	localparam int         IDX_W         = 4;
	localparam logic [COUNT_W-1:0] COUNT_CRC_LAST = 5'd14;
	localparam logic [COUNT_W-1:0] COUNT_CHECK    = 5'd15;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = 5'd17;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} wfc_in_t;

	typedef struct packed {
		logic               frame_ok;
		logic [7:0]         sensor_id;
		logic signed [15:0] temperature_tenths;
		logic [7:0]         humidity_percent;
		logic [15:0]        wind_speed_tenths;
		logic [15:0]        wind_gust_tenths;
		logic [15:0]        wind_direction_deg;
		logic [9:0]         rain_tenths_mm;
		logic [7:0]         uv_index;
		logic [19:0]        ambient_lux;
		logic               battery_low;
	} wfc_out_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- design/weather_frame_crc8_decoder_top.sv -----
// weather sensor frame decoder with crc8 check, single pass top level
// a result is registered in the output register when its last beat leaves the input stage
// one input beat per cycle, but a last beat stalls while an untaken result is held
// a result waits in the output register while further beats are taken
// reset clears the counter, crc, preamble flag and valid flags
// the payload bytes are not cleared; only bytes of the current frame reach a result
`timescale 1ns / 1ps

module weather_frame_crc8_decoder_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  wfcrc8_pkg::wfc_in_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output wfcrc8_pkg::wfc_out_t  out_data
);

	logic                           valid_s1;
	wfcrc8_pkg::wfc_in_t            data_s1;
	logic [wfcrc8_pkg::COUNT_W-1:0] count_q;
	logic [7:0]                     crc_q;
	logic                           preamble_q;
	logic [7:0]                     store_q [wfcrc8_pkg::PAYLOAD_DEPTH];
	logic                           out_valid_q;
	wfcrc8_pkg::wfc_out_t           out_data_q;

	logic                           advance;
	logic                           ok;
	logic [wfcrc8_pkg::IDX_W-1:0]   store_idx;
	logic [15:0]                    ambient_raw;
	wfcrc8_pkg::wfc_out_t           result;

	assign advance   = valid_s1 && (!data_s1.frame_end || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign store_idx = count_q[wfcrc8_pkg::IDX_W-1:0] - {{(wfcrc8_pkg::IDX_W-1){1'b0}}, 1'b1};
	assign ok = data_s1.frame_end && (count_q == wfcrc8_pkg::COUNT_CHECK) && preamble_q
		&& (crc_q == data_s1.data_byte);
	assign ambient_raw = {store_q[12], store_q[13]};

	always_comb begin
		result = '0;
		if (ok) begin
			result.frame_ok           = 1'b1;
			result.sensor_id          = store_q[0];
			result.temperature_tenths = {store_q[1], store_q[2]};
			result.humidity_percent   = store_q[3];
			result.wind_speed_tenths  = {store_q[4], store_q[5]};
			result.wind_gust_tenths   = {store_q[6], store_q[7]};
			result.wind_direction_deg = {store_q[8], store_q[9]};
			result.rain_tenths_mm     = {1'b0, store_q[10], 1'b0} + {2'b00, store_q[10]};
			result.uv_index           = store_q[11];
			result.ambient_lux        = {1'b0, ambient_raw, 3'b000} + {3'b000, ambient_raw, 1'b0};
			result.battery_low        = |(store_q[0] & wfcrc8_pkg::BATTERY_MASK);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			count_q     <= '0;
			crc_q       <= '0;
			preamble_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance && data_s1.frame_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (data_s1.frame_end) begin
					count_q    <= '0;
					crc_q      <= '0;
					preamble_q <= 1'b0;
				end else begin
					if (count_q < wfcrc8_pkg::COUNT_MAX) begin
						count_q <= count_q + 1'b1;
					end
					if (count_q <= wfcrc8_pkg::COUNT_CRC_LAST) begin
						crc_q <= wfcrc8_pkg::crc8_update(crc_q, data_s1.data_byte);
					end
					if (count_q == '0) begin
						preamble_q <= (data_s1.data_byte == wfcrc8_pkg::PREAMBLE_BYTE);
					end
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
		if (advance && count_q != '0 && count_q <= wfcrc8_pkg::COUNT_CRC_LAST) begin
			store_q[store_idx] <= data_s1.data_byte;
		end
		if (advance && data_s1.frame_end) begin
			out_data_q <= result;
		end
	end

endmodule

// ----- sim/tb.sv -----
// testbench for the weather frame crc8 decoder: random framed byte traffic with a scoreboard
`timescale 1ns / 1ps

class frame_scoreboard;
	wfcrc8_pkg::wfc_out_t pending[$];
	int                   errors;
	logic [4:0]           byte_idx;
	logic [7:0]           crc_acc;
	bit                   pre_ok;
	logic [7:0]           payload [wfcrc8_pkg::PAYLOAD_DEPTH];

	function new();
		errors   = 0;
		byte_idx = '0;
		crc_acc  = '0;
		pre_ok   = 0;
		foreach (payload[i]) payload[i] = '0;
	endfunction

	// bit-serial form, msb first
	function logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] r;
		logic       fb;
		r = c;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ b[i];
			r = {r[6:0], 1'b0};
			if (fb) begin
				r = r ^ wfcrc8_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

	function void note_beat(input wfcrc8_pkg::wfc_in_t beat);
		logic [4:0]           idx;
		bit                   ok;
		wfcrc8_pkg::wfc_out_t res;
		idx = byte_idx;
		if (idx < wfcrc8_pkg::COUNT_CHECK) begin
			if (idx == 0) begin
				pre_ok = (beat.data_byte == wfcrc8_pkg::PREAMBLE_BYTE);
			end else begin
				payload[idx - 1] = beat.data_byte;
			end
		end
		ok = beat.frame_end && idx == wfcrc8_pkg::COUNT_CHECK && pre_ok
			&& crc_acc == beat.data_byte;
		if (idx < wfcrc8_pkg::COUNT_CHECK) begin
			crc_acc = crc_step(crc_acc, beat.data_byte);
		end
		if (byte_idx < wfcrc8_pkg::COUNT_MAX) begin
			byte_idx = byte_idx + 5'd1;
		end
		if (!beat.frame_end) begin
			return;
		end
		res = '0;
		if (ok) begin
			res.frame_ok           = 1'b1;
			res.sensor_id          = payload[0];
			res.temperature_tenths = {payload[1], payload[2]};
			res.humidity_percent   = payload[3];
			res.wind_speed_tenths  = {payload[4], payload[5]};
			res.wind_gust_tenths   = {payload[6], payload[7]};
			res.wind_direction_deg = {payload[8], payload[9]};
			res.rain_tenths_mm     = 10'(int'(payload[10]) * 3);
			res.uv_index           = payload[11];
			res.ambient_lux        = 20'(int'({payload[12], payload[13]}) * 10);
			res.battery_low        = (payload[0] & wfcrc8_pkg::BATTERY_MASK) != 0;
		end
		pending.push_back(res);
		byte_idx = '0;
		crc_acc  = '0;
		pre_ok   = 0;
	endfunction

	function void cmp(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	function void check_result(input wfcrc8_pkg::wfc_out_t got);
		wfcrc8_pkg::wfc_out_t want;
		if (pending.size() == 0) begin
			$error("result with no frame pending");
			errors++;
			return;
		end
		want = pending.pop_front();
		cmp("frame_ok", 32'(want.frame_ok), 32'(got.frame_ok));
		cmp("sensor_id", 32'(want.sensor_id), 32'(got.sensor_id));
		cmp("temperature_tenths", 32'(want.temperature_tenths), 32'(got.temperature_tenths));
		cmp("humidity_percent", 32'(want.humidity_percent), 32'(got.humidity_percent));
		cmp("wind_speed_tenths", 32'(want.wind_speed_tenths), 32'(got.wind_speed_tenths));
		cmp("wind_gust_tenths", 32'(want.wind_gust_tenths), 32'(got.wind_gust_tenths));
		cmp("wind_direction_deg", 32'(want.wind_direction_deg), 32'(got.wind_direction_deg));
		cmp("rain_tenths_mm", 32'(want.rain_tenths_mm), 32'(got.rain_tenths_mm));
		cmp("uv_index", 32'(want.uv_index), 32'(got.uv_index));
		cmp("ambient_lux", 32'(want.ambient_lux), 32'(got.ambient_lux));
		cmp("battery_low", 32'(want.battery_low), 32'(got.battery_low));
	endfunction
endclass

module tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int BEAT_TARGET = 750;
	localparam int QUIET_FROM  = 650;
	localparam int DRAIN_WAIT  = 10;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	wfcrc8_pkg::wfc_in_t  in_data;
	logic                 out_valid;
	logic                 out_ready;
	wfcrc8_pkg::wfc_out_t out_data;

	frame_scoreboard sb;
	logic [7:0]      frame_buf[$];
	int              sent_beats;
	int              cycles = 0;
	bit              quiet;

	weather_frame_crc8_decoder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(out_data);
		end
	end

	// result side back-pressure
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				@(negedge clk);
				out_ready <= 1'b1;
			end else begin
				n = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 20);
				repeat (n) begin
					@(negedge clk);
					out_ready <= 1'b1;
				end
				if (!quiet && $urandom_range(0, 1) == 0) begin
					repeat ($urandom_range(1, 12)) begin
						@(negedge clk);
						out_ready <= 1'b0;
					end
				end
			end
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic last);
		wfcrc8_pkg::wfc_in_t beat;
		beat.data_byte = b;
		beat.frame_end = last;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(beat);
		sent_beats++;
	endtask

	task automatic sender_gap(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] frame_crc();
		logic [7:0] c;
		c = '0;
		for (int i = 0; i < 15; i++) begin
			c = sb.crc_step(c, frame_buf[i]);
		end
		return c;
	endfunction

	// fill: 0 random, 1 all ones, 2 all zeros
	task automatic build_good(input int fill);
		frame_buf.delete();
		frame_buf.push_back(wfcrc8_pkg::PREAMBLE_BYTE);
		for (int i = 0; i < wfcrc8_pkg::PAYLOAD_DEPTH; i++) begin
			case (fill)
				1: frame_buf.push_back(8'hFF);
				2: frame_buf.push_back(8'h00);
				default: frame_buf.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		frame_buf.push_back(frame_crc());
	endtask

	task automatic send_frame();
		bit calm;
		calm = quiet || ($urandom_range(0, 3) == 0);
		for (int i = 0; i < frame_buf.size(); i++) begin
			if (!calm && $urandom_range(0, 4) == 0) begin
				sender_gap($urandom_range(1, 12));
			end
			send_beat(frame_buf[i], i == frame_buf.size() - 1);
		end
	endtask

	initial begin
		int kind;
		int len;
		sb         = new();
		sent_beats = 0;
		quiet      = 0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// good frame at the top of every field
		build_good(1);
		send_frame();
		// one-beat frame of zero
		send_beat(8'h00, 1'b1);
		// preamble byte as a one-beat frame
		send_beat(wfcrc8_pkg::PREAMBLE_BYTE, 1'b1);
		wait_drained();

		while (sent_beats < BEAT_TARGET) begin
			quiet = (sent_beats >= QUIET_FROM);
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				case ($urandom_range(0, 11))
					0: build_good(1);
					1: build_good(2);
					default: build_good(0);
				endcase
			end else if (kind < 75) begin
				// crc mismatch
				build_good(0);
				frame_buf[15] = frame_buf[15] ^ 8'($urandom_range(1, 255));
			end else if (kind < 82) begin
				// wrong preamble, crc consistent
				build_good(0);
				frame_buf[0] = 8'($urandom_range(0, 254));
				frame_buf[15] = frame_crc();
			end else if (kind < 91) begin
				// short frame
				build_good(0);
				len = $urandom_range(1, 15);
				while (frame_buf.size() > len) void'(frame_buf.pop_back());
				if ($urandom_range(0, 3) == 0) begin
					frame_buf[0] = 8'($urandom_range(0, 255));
				end
			end else begin
				// long frame
				build_good(0);
				repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom_range(0, 255)));
			end
			send_frame();
			if (!quiet && $urandom_range(0, 14) == 0) begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$error("frames without result: %0d", sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/wfcrc8_pkg.sv
design/weather_frame_crc8_decoder_top.sv
sim/tb.sv
